@@ rtl/core/sparse_entry_index_reorder_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sparse entry index reorder unit
// Clocked concurrent checks, both disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SPARSE_ENTRY_INDEX_REORDER_UNIT_ASSERT_SVH
`define SPARSE_ENTRY_INDEX_REORDER_UNIT_ASSERT_SVH

// Property that must hold on every edge outside reset.
`define SEIRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define SEIRU_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

@@ rtl/core/seiru_pkg.sv @@
// ----------------------------------------------------------------------------
// seiru_pkg
// Shared widths, register codes and types of the index reorder unit.
// ----------------------------------------------------------------------------
package seiru_pkg;

  localparam int IDX_W          = 32;
  localparam int VAL_W          = 64;
  localparam int EQN_W          = 8;
  localparam int GRID_W         = 16;
  localparam int SIZE_W         = IDX_W + EQN_W;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int INDEX_BITS_DEF = 32;
  // two dividers of IDX_W stages each, then three arithmetic stages
  localparam int LANE_LAT       = 2 * IDX_W + 3;

  typedef enum logic [1:0] {
    MODE_BY_NODES,
    MODE_BY_VARS,
    MODE_GRID_X,
    MODE_GRID_Y
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_EQN,
    REG_BLOCK_ROWS,
    REG_GRID_NX,
    REG_GRID_NY
  } reg_e;

  typedef struct packed {
    mode_e              mode;
    logic [EQN_W-1:0]   eqn;
    logic [IDX_W-1:0]   block_rows;
    logic [GRID_W-1:0]  grid_nx;
    logic [GRID_W-1:0]  grid_ny;
  } cfg_t;

endpackage

@@ rtl/core/seiru_if.sv @@
// ----------------------------------------------------------------------------
// seiru interfaces
// Valid/ready channels for entries in, entries out and register writes.
// ----------------------------------------------------------------------------
interface seiru_in_if;
  logic                   valid;
  logic                   ready;
  logic [seiru_pkg::IDX_W-1:0] src_row;
  logic [seiru_pkg::IDX_W-1:0] src_col;
  logic [seiru_pkg::VAL_W-1:0] entry_value;
  modport source (output valid, src_row, src_col, entry_value, input ready);
  modport sink   (input valid, src_row, src_col, entry_value, output ready);
endinterface

interface seiru_out_if;
  logic                   valid;
  logic                   ready;
  logic [seiru_pkg::IDX_W-1:0] new_row;
  logic [seiru_pkg::IDX_W-1:0] new_col;
  logic [seiru_pkg::VAL_W-1:0] value_out;
  logic                   index_error;
  modport source (output valid, new_row, new_col, value_out, index_error, input ready);
  modport sink   (input valid, new_row, new_col, value_out, index_error, output ready);
endinterface

interface seiru_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [seiru_pkg::CFG_IDX_W-1:0]  index;
  logic [seiru_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/seiru_div.sv @@
// ----------------------------------------------------------------------------
// seiru_div
// Pipelined restoring divider, one quotient bit per stage, side data carried.
// ----------------------------------------------------------------------------
module seiru_div #(
  parameter int W  = 32,
  parameter int SW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  dvd_i,
  input  logic [W-1:0]  dsr_i,
  input  logic [SW-1:0] side_i,
  output logic [W-1:0]  quo_o,
  output logic [W-1:0]  rem_o,
  output logic [SW-1:0] side_o
);

  logic [W-1:0]  rem_q  [W];
  logic [W-1:0]  dvd_q  [W];
  logic [SW-1:0] side_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0]  rem_in;
    logic [W-1:0]  dvd_in;
    logic [SW-1:0] side_in;
    logic [W:0]    trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign dvd_in  = dvd_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign dvd_in  = dvd_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, dvd_in[W-1]};
    assign take  = trial >= {1'b0, dsr_i};

    // quotient bits shift in from the bottom as dividend bits leave the top
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? W'(trial - {1'b0, dsr_i}) : trial[W-1:0];
        dvd_q[k]  <= {dvd_in[W-2:0], take};
        side_q[k] <= side_in;
      end
    end
  end

  assign quo_o  = dvd_q[W-1];
  assign rem_o  = rem_q[W-1];
  assign side_o = side_q[W-1];

endmodule

@@ rtl/core/seiru_lane.sv @@
// ----------------------------------------------------------------------------
// seiru_lane
// Applies the selected permutation to one index: two dividers, then arithmetic.
// ----------------------------------------------------------------------------
module seiru_lane (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  seiru_pkg::cfg_t              cfg_i,
  input  logic [seiru_pkg::IDX_W-1:0]  x_i,
  output logic [seiru_pkg::IDX_W-1:0]  p_o,
  output logic [seiru_pkg::IDX_W-1:0]  x_o
);
  import seiru_pkg::*;

  logic [IDX_W-1:0]  d1, c_div;
  logic [GRID_W-1:0] a_mul;
  logic              grid;
  logic [IDX_W-1:0]  q1, r1, x1, q2, r2, x2, q1b, r1b;
  logic [IDX_W-1:0]  m1;

  logic [IDX_W-1:0] m1_q, q1_m1_q, q2_m1_q, r1_m1_q, x_m1_q;
  logic [IDX_W-1:0] s_q, r1_m2_q, x_m2_q;
  logic [IDX_W-1:0] p_q, x_m3_q;

  assign grid = (cfg_i.mode == MODE_GRID_X) || (cfg_i.mode == MODE_GRID_Y);

  always_comb begin
    d1    = {{(IDX_W-EQN_W){1'b0}}, cfg_i.eqn};
    c_div = {{(IDX_W-GRID_W){1'b0}}, cfg_i.grid_nx};
    a_mul = cfg_i.grid_ny;
    case (cfg_i.mode)
      MODE_BY_NODES: d1 = cfg_i.block_rows;
      MODE_GRID_X: begin
        c_div = {{(IDX_W-GRID_W){1'b0}}, cfg_i.grid_ny};
        a_mul = cfg_i.grid_nx;
      end
      default: ;
    endcase
  end

  seiru_div #(.W(IDX_W), .SW(IDX_W)) u_div_first (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .dvd_i  (x_i),
    .dsr_i  (d1),
    .side_i (x_i),
    .quo_o  (q1),
    .rem_o  (r1),
    .side_o (x1)
  );

  seiru_div #(.W(IDX_W), .SW(3*IDX_W)) u_div_second (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .dvd_i  (q1),
    .dsr_i  (c_div),
    .side_i ({x1, r1, q1}),
    .quo_o  (q2),
    .rem_o  (r2),
    .side_o ({x2, r1b, q1b})
  );

  always_comb begin
    case (cfg_i.mode)
      MODE_BY_NODES: m1 = IDX_W'(cfg_i.eqn * r1b);
      MODE_BY_VARS:  m1 = IDX_W'(r1b * cfg_i.block_rows);
      default:       m1 = IDX_W'(r2 * a_mul);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q    <= m1;
      q1_m1_q <= q1b;
      q2_m1_q <= q2;
      r1_m1_q <= r1b;
      x_m1_q  <= x2;
      s_q     <= m1_q + (grid ? q2_m1_q : q1_m1_q);
      r1_m2_q <= r1_m1_q;
      x_m2_q  <= x_m1_q;
      p_q     <= grid ? IDX_W'(cfg_i.eqn * s_q) + r1_m2_q : s_q;
      x_m3_q  <= x_m2_q;
    end
  end

  assign p_o = p_q;
  assign x_o = x_m3_q;

endmodule

@@ rtl/core/sparse_entry_index_reorder_unit.sv @@
// ----------------------------------------------------------------------------
// sparse_entry_index_reorder_unit
// Symmetric permutation of one sparse-matrix nonzero per beat.
// ----------------------------------------------------------------------------
// Takes one nonzero (row, column, value bits) per beat and returns it with row
// and column passed through the permutation chosen by reorder_mode; the value
// passes untouched. One beat is accepted every cycle while the output side
// keeps up. Indices are 32 bits wide, independent of INDEX_BITS: each index
// lane is two 32-stage restoring dividers (one quotient bit per stage) and
// three multiply/add stages, and the merge adds the output register. The
// whole pipeline advances together and holds when a finished beat waits at
// the output. index_error flags entries outside the matrix (size zero, size
// above 2^INDEX_BITS, or an index at or beyond the size) and zeroes both
// indices. The user must write registers only with the pipeline drained; the block does not enforce this.
`include "sparse_entry_index_reorder_unit_assert.svh"

module sparse_entry_index_reorder_unit #(
  parameter int INDEX_BITS = seiru_pkg::INDEX_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  seiru_in_if.sink    in_if,
  seiru_out_if.source out_if,
  seiru_cfg_if.sink   cfg_if
);
  import seiru_pkg::*;

  localparam int LAT   = LANE_LAT;
  localparam int CMP_W = (INDEX_BITS + 2 > SIZE_W + 1) ? INDEX_BITS + 2 : SIZE_W + 1;
  localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << INDEX_BITS;

  // configuration registers
  cfg_t cfg_q;

  // matrix size, registered through nxny_q and size_q after a write
  logic [IDX_W-1:0]  nxny_q;
  logic [SIZE_W-1:0] size_q;
  logic              bad_cfg_q;

  // pipeline control and value delay line
  logic             en;
  logic [LAT-1:0]   vld_q;
  logic [VAL_W-1:0] val_q [LAT];

  // lane results
  logic [IDX_W-1:0] p_row, p_col, x_row, x_col;
  logic             bad;

  // output register
  logic             out_vld_q;
  logic [IDX_W-1:0] row_q, col_q;
  logic [VAL_W-1:0] out_val_q;
  logic             err_q;

  // --- configuration port: always ready, unknown indexes dropped ---
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= MODE_BY_NODES;
      cfg_q.eqn        <= EQN_W'(1);
      cfg_q.block_rows <= IDX_W'(1);
      cfg_q.grid_nx    <= GRID_W'(1);
      cfg_q.grid_ny    <= GRID_W'(1);
    end else if (cfg_if.valid) begin
      case (reg_e'(cfg_if.index))
        REG_MODE:       cfg_q.mode       <= mode_e'(cfg_if.data[1:0]);
        REG_EQN:        cfg_q.eqn        <= cfg_if.data[EQN_W-1:0];
        REG_BLOCK_ROWS: cfg_q.block_rows <= cfg_if.data[IDX_W-1:0];
        REG_GRID_NX:    cfg_q.grid_nx    <= cfg_if.data[GRID_W-1:0];
        REG_GRID_NY:    cfg_q.grid_ny    <= cfg_if.data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // size settles after a write, long before a beat reaches the merge
  always_ff @(posedge clk_i) begin
    nxny_q <= cfg_q.grid_nx * cfg_q.grid_ny;
    if ((cfg_q.mode == MODE_BY_NODES) || (cfg_q.mode == MODE_BY_VARS)) begin
      size_q <= SIZE_W'(cfg_q.eqn) * SIZE_W'(cfg_q.block_rows);
    end else begin
      size_q <= SIZE_W'(cfg_q.eqn) * SIZE_W'(nxny_q);
    end
    bad_cfg_q <= (size_q == '0) || (CMP_W'(size_q) > LIMIT);
  end

  // --- pipeline: one shared enable, stall only when the output is held ---
  assign en          = !out_vld_q || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_if.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q[0] <= in_if.entry_value;
      for (int k = 1; k < LAT; k++) begin
        val_q[k] <= val_q[k-1];
      end
    end
  end

  // --- two lanes: rows and columns see the same map ---
  seiru_lane u_lane_row (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg_q),
    .x_i   (in_if.src_row),
    .p_o   (p_row),
    .x_o   (x_row)
  );

  seiru_lane u_lane_col (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg_q),
    .x_i   (in_if.src_col),
    .p_o   (p_col),
    .x_o   (x_col)
  );

  // --- merge: range check on the carried source indices ---
  assign bad = bad_cfg_q
            || ({{EQN_W{1'b0}}, x_row} >= size_q)
            || ({{EQN_W{1'b0}}, x_col} >= size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      row_q     <= bad ? '0 : p_row;
      col_q     <= bad ? '0 : p_col;
      out_val_q <= val_q[LAT-1];
      err_q     <= bad;
    end
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.new_row     = row_q;
  assign out_if.new_col     = col_q;
  assign out_if.value_out   = out_val_q;
  assign out_if.index_error = err_q;

  // --- checks ---
  `SEIRU_ASSERT(a_last_to_out, en && vld_q[LAT-1] |=> out_vld_q, "beat lost at merge")
  `SEIRU_ASSERT(a_hold_pipe, !en |=> $stable(vld_q), "pipeline moved while stalled")
  `SEIRU_ASSERT_NEVER(a_err_zero, out_vld_q && err_q && ((row_q != '0) || (col_q != '0)),
    "flagged beat carries nonzero index")

endmodule
